### design/ac_ir_frame_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// AC IR frame encoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AC_IR_FRAME_ENCODER_CORE_DEFINES_SVH
`define AC_IR_FRAME_ENCODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/acir_enc_pkg.sv
// ----------------------------------------------------------------------------
// AC IR frame encoder package
// Frame layout constants, register indexes, timing defaults and code tables.
// ----------------------------------------------------------------------------
package acir_enc_pkg;

    localparam int FRAME_LEN  = 9;
    localparam int FRAME_BITS = FRAME_LEN * 8;
    localparam int DUR_W      = 16;
    localparam int IDX_W      = $clog2(FRAME_BITS + 2);
    localparam int BIT_SEL_W  = $clog2(FRAME_BITS);

    // Pair sequence: header, then one pair per frame bit, then the footer.
    localparam logic [IDX_W-1:0] PAIR_HEADER = '0;
    localparam logic [IDX_W-1:0] PAIR_FOOTER = IDX_W'(FRAME_BITS + 1);

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_NEXT  = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        CFG_HEADER_MARK  = 3'd0,
        CFG_HEADER_SPACE = 3'd1,
        CFG_BIT_MARK     = 3'd2,
        CFG_ONE_SPACE    = 3'd3,
        CFG_ZERO_SPACE   = 3'd4,
        CFG_GAP_SPACE    = 3'd5
    } t_cfg_reg;

    localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 16'd8500;
    localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd4200;
    localparam logic [DUR_W-1:0] RST_BIT_MARK     = 16'd500;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1600;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd550;
    localparam logic [DUR_W-1:0] RST_GAP_SPACE    = 16'd30000;

    typedef logic [7:0] t_byte;

    localparam t_byte TPL_BYTE0 = 8'h6A;
    localparam t_byte TPL_BYTE1 = 8'h6D;
    localparam t_byte TPL_BYTE2 = 8'h51;
    localparam t_byte TPL_BYTE4 = 8'h10;
    localparam t_byte TPL_BYTE5 = 8'h45;
    localparam t_byte TPL_BYTE8 = 8'h33;
    localparam t_byte TEMP_MASK = 8'h1F;
    localparam t_byte MODE_FAN_MASK = 8'h77;

    localparam logic [7:0] TEMP_MIN    = 8'd16;
    localparam logic [7:0] TEMP_MAX    = 8'd30;
    localparam logic [7:0] TEMP_OFFSET = 8'd4;

    localparam logic [2:0] SWING_AUTO_CODE  = 3'd0;
    localparam logic [2:0] SWING_FIXED_CODE = 3'd5;
    localparam logic [1:0] POWER_ON_CODE    = 2'b10;
    localparam logic [1:0] POWER_OFF_CODE   = 2'b01;

    // Mode as sent on air; fan-only and unused codes go out as auto.
    function automatic logic [2:0] mode_code(input logic [2:0] mode);
        logic [2:0] code;
        unique case (mode)
            3'd1:    code = 3'd2;
            3'd2:    code = 3'd3;
            3'd3:    code = 3'd1;
            default: code = 3'd4;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] fan_code(input logic [1:0] fan);
        logic [1:0] code;
        unique case (fan)
            2'd0:    code = 2'd0;
            2'd1:    code = 2'd2;
            2'd2:    code = 2'd3;
            default: code = 2'd1;
        endcase
        return code;
    endfunction

endpackage

### design/acir_in_if.sv
// ----------------------------------------------------------------------------
// AC IR frame encoder request channel
// Valid/ready channel carrying a start or next request with the settings.
// ----------------------------------------------------------------------------
interface acir_in_if;

    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] temp_c;
    logic [2:0] mode;
    logic [1:0] fan;
    logic       swing;
    logic       power;

    modport source (
        output valid, action, temp_c, mode, fan, swing, power,
        input  ready
    );

    modport sink (
        input  valid, action, temp_c, mode, fan, swing, power,
        output ready
    );

endinterface

### design/acir_out_if.sv
// ----------------------------------------------------------------------------
// AC IR frame encoder pair channel
// Valid/ready channel carrying one mark/space pair and the end-of-frame flag.
// ----------------------------------------------------------------------------
interface acir_out_if;

    logic        valid;
    logic        ready;
    logic [15:0] mark_us;
    logic [15:0] space_us;
    logic        last;

    modport source (
        output valid, mark_us, space_us, last,
        input  ready
    );

    modport sink (
        input  valid, mark_us, space_us, last,
        output ready
    );

endinterface

### design/acir_frame_build.sv
// ----------------------------------------------------------------------------
// AC IR frame builder
// Fills the frame template with the settings and appends the nibble checksum.
// ----------------------------------------------------------------------------
module acir_frame_build import acir_enc_pkg::*; (
    input  logic [7:0]            i_temp_c,
    input  logic [2:0]            i_mode,
    input  logic [1:0]            i_fan,
    input  logic                  i_swing,
    input  logic                  i_power,
    output logic [FRAME_BITS-1:0] o_frame
);

    logic [7:0] w_temp;
    logic [4:0] w_temp_code;
    t_byte      w_bytes [FRAME_LEN];
    t_byte      w_sum;

    always_comb begin
        if (i_temp_c < TEMP_MIN) begin
            w_temp = TEMP_MIN;
        end else if (i_temp_c > TEMP_MAX) begin
            w_temp = TEMP_MAX;
        end else begin
            w_temp = i_temp_c;
        end
        w_temp_code = 5'(w_temp - TEMP_OFFSET);
    end

    always_comb begin
        w_bytes[0] = TPL_BYTE0;
        w_bytes[1] = (TPL_BYTE1 & ~TEMP_MASK) | {3'b000, w_temp_code};
        w_bytes[2] = TPL_BYTE2;
        w_bytes[3] = 8'h00;
        w_bytes[4] = (TPL_BYTE4 & ~MODE_FAN_MASK)
                   | {1'b0, mode_code(i_mode), 2'b00, fan_code(i_fan)};
        w_bytes[5] = {(i_power ? POWER_ON_CODE : POWER_OFF_CODE), 3'b000,
                      (i_swing ? SWING_AUTO_CODE : SWING_FIXED_CODE)};
        w_bytes[6] = 8'h00;
        w_bytes[7] = 8'h00;
        w_bytes[8] = TPL_BYTE8;

        // Checksum is the sum of both nibbles of every byte before it.
        w_sum = '0;
        for (int k = 0; k < FRAME_LEN - 1; k++) begin
            w_sum = w_sum + {4'h0, w_bytes[k][7:4]} + {4'h0, w_bytes[k][3:0]};
        end
        w_bytes[FRAME_LEN-1] = w_sum;

        for (int k = 0; k < FRAME_LEN; k++) begin
            o_frame[8*k +: 8] = w_bytes[k];
        end
    end

endmodule

### design/ac_ir_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// AC IR frame encoder core
// Turns air conditioner settings into a pulse-distance IR frame, one
// mark/space pair per request.
//
// Requests arrive on i_in. A transfer with action start builds the 9-byte
// frame (clamped temperature, mode, fan, swing, power, nibble checksum) and
// produces nothing; it also restarts a frame that is still being sent. Each
// next transfer then produces one pair on o_out: the header, 72 data bits
// LSB-first from byte 0, and the footer (bit mark plus gap) with last set.
// A next transfer while no frame is active is taken and dropped.
// Pair timings come from six 16-bit registers written through the i_cfg_*
// port; they should only be changed while the block is idle.
// A pair appears on o_out in the cycle after its request transfer, and one
// request can be taken every cycle: the output register is refilled in the
// same cycle its pair is taken. While the receiver stalls with a pair held,
// i_in.ready is low and all state stays put.
// Reset returns the timings to their defaults, drops any held pair and
// leaves no frame active; the frame bytes themselves are not cleared.
// ----------------------------------------------------------------------------
`include "ac_ir_frame_encoder_core_defines.svh"

module ac_ir_frame_encoder_core import acir_enc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [DUR_W-1:0]  i_cfg_data,
    acir_in_if.sink           i_in,
    acir_out_if.source        o_out
);

    // Timing registers.
    logic [DUR_W-1:0] r_header_mark, r_header_space, r_bit_mark;
    logic [DUR_W-1:0] r_one_space, r_zero_space, r_gap_space;

    // Frame state.
    logic [FRAME_BITS-1:0] r_frame;
    logic [IDX_W-1:0]      r_pair_idx, n_pair_idx;
    logic                  r_busy, n_busy;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic [DUR_W-1:0] r_out_mark, n_out_mark;
    logic [DUR_W-1:0] r_out_space, n_out_space;
    logic             r_out_last, n_out_last;

    logic                  w_in_xfer, w_out_xfer, w_start, w_emit;
    logic [FRAME_BITS-1:0] w_new_frame;
    logic [BIT_SEL_W-1:0]  w_bit_sel;

    // A held pair only blocks new requests when the receiver is not taking it.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = r_out_valid && o_out.ready;
    assign w_start    = w_in_xfer && (i_in.action == ACT_START);
    assign w_emit     = w_in_xfer && (i_in.action == ACT_NEXT) && r_busy;

    acir_frame_build u_frame_build (
        .i_temp_c (i_in.temp_c),
        .i_mode   (i_in.mode),
        .i_fan    (i_in.fan),
        .i_swing  (i_in.swing),
        .i_power  (i_in.power),
        .o_frame  (w_new_frame)
    );

    // Data pair k (1..72) sends frame bit k-1.
    assign w_bit_sel = BIT_SEL_W'(r_pair_idx - IDX_W'(1));

    always_comb begin
        n_pair_idx  = r_pair_idx;
        n_busy      = r_busy;
        n_out_valid = w_out_xfer ? 1'b0 : r_out_valid;
        n_out_mark  = r_out_mark;
        n_out_space = r_out_space;
        n_out_last  = r_out_last;

        if (w_start) begin
            n_pair_idx = PAIR_HEADER;
            n_busy     = 1'b1;
        end else if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_last  = 1'b0;
            if (r_pair_idx == PAIR_HEADER) begin
                n_out_mark  = r_header_mark;
                n_out_space = r_header_space;
            end else if (r_pair_idx < PAIR_FOOTER) begin
                n_out_mark  = r_bit_mark;
                n_out_space = r_frame[w_bit_sel] ? r_one_space : r_zero_space;
            end else begin
                n_out_mark  = r_bit_mark;
                n_out_space = r_gap_space;
                n_out_last  = 1'b1;
            end

            if (r_pair_idx >= PAIR_FOOTER) begin
                n_pair_idx = PAIR_HEADER;
                n_busy     = 1'b0;
            end else begin
                n_pair_idx = r_pair_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_mark  <= RST_HEADER_MARK;
            r_header_space <= RST_HEADER_SPACE;
            r_bit_mark     <= RST_BIT_MARK;
            r_one_space    <= RST_ONE_SPACE;
            r_zero_space   <= RST_ZERO_SPACE;
            r_gap_space    <= RST_GAP_SPACE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEADER_MARK:  r_header_mark  <= i_cfg_data;
                CFG_HEADER_SPACE: r_header_space <= i_cfg_data;
                CFG_BIT_MARK:     r_bit_mark     <= i_cfg_data;
                CFG_ONE_SPACE:    r_one_space    <= i_cfg_data;
                CFG_ZERO_SPACE:   r_zero_space   <= i_cfg_data;
                CFG_GAP_SPACE:    r_gap_space    <= i_cfg_data;
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_idx  <= PAIR_HEADER;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pair_idx  <= n_pair_idx;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_frame <= w_new_frame;
        end
        r_out_mark  <= n_out_mark;
        r_out_space <= n_out_space;
        r_out_last  <= n_out_last;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.mark_us  = r_out_mark;
    assign o_out.space_us = r_out_space;
    assign o_out.last     = r_out_last;

    // Checks on the pair sequencer.
    `ACIR_ASSERT_NOW(a_idle_idx_zero, !r_busy, r_pair_idx == PAIR_HEADER, "idle with nonzero pair index")
    `ACIR_ASSERT_NOW(a_idx_in_range, 1'b1, r_pair_idx <= PAIR_FOOTER, "pair index past footer")
    `ACIR_ASSERT_NEXT(a_footer_ends, w_emit && r_pair_idx == PAIR_FOOTER, !r_busy && r_out_valid && r_out_last, "footer did not end the frame")
    `ACIR_ASSERT_NEXT(a_no_spurious_pair, w_in_xfer && !w_emit, !r_out_valid, "pair produced without a next request")

endmodule

### tb/tb_ac_ir_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// Testbench for the AC IR frame encoder core
// Drives start and next requests with random pacing on both channels, builds
// each frame independently and checks every mark/space pair in order against
// the predicted one, over several pair-timing settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ac_ir_frame_encoder_core;
    import acir_enc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned FRAME_PAIRS   = FRAME_BITS + 2;

    typedef struct packed {
        t_action    action;
        logic [7:0] temp_c;
        logic [2:0] mode;
        logic [1:0] fan;
        logic       swing;
        logic       power;
    } t_request;

    typedef struct packed {
        logic [15:0] mark_us;
        logic [15:0] space_us;
        logic        last;
    } t_pair;

    typedef logic [15:0] t_timings [6];

    // Tracks the frame being sent and the pairs still owed by the block.
    class ir_pair_tracker;
        logic [15:0] timing [6];
        t_byte       frame [FRAME_LEN];
        int unsigned pair_idx;
        bit          frame_active;
        t_pair       pending_pairs [$];
        int unsigned error_count;

        function new();
            timing[CFG_HEADER_MARK]  = RST_HEADER_MARK;
            timing[CFG_HEADER_SPACE] = RST_HEADER_SPACE;
            timing[CFG_BIT_MARK]     = RST_BIT_MARK;
            timing[CFG_ONE_SPACE]    = RST_ONE_SPACE;
            timing[CFG_ZERO_SPACE]   = RST_ZERO_SPACE;
            timing[CFG_GAP_SPACE]    = RST_GAP_SPACE;
            pair_idx     = 0;
            frame_active = 1'b0;
            error_count  = 0;
        endfunction

        function void set_timing(t_cfg_reg reg_sel, logic [15:0] value);
            timing[reg_sel] = value;
        endfunction

        function void build_frame(t_request r);
            logic [7:0] temp;
            logic [7:0] sum;
            logic [2:0] air_mode;
            logic [1:0] air_fan;
            temp = r.temp_c;
            if (temp < TEMP_MIN) temp = TEMP_MIN;
            if (temp > TEMP_MAX) temp = TEMP_MAX;
            // Fan-only and the unused mode codes go out as auto.
            air_mode = (r.mode == 3'd1) ? 3'd2 :
                       (r.mode == 3'd2) ? 3'd3 :
                       (r.mode == 3'd3) ? 3'd1 : 3'd4;
            air_fan  = (r.fan == 2'd1) ? 2'd2 :
                       (r.fan == 2'd2) ? 2'd3 :
                       (r.fan == 2'd3) ? 2'd1 : 2'd0;
            frame[0] = TPL_BYTE0;
            frame[1] = (TPL_BYTE1 & ~TEMP_MASK) | ((temp - TEMP_OFFSET) & TEMP_MASK);
            frame[2] = TPL_BYTE2;
            frame[3] = 8'h00;
            frame[4] = (TPL_BYTE4 & ~MODE_FAN_MASK) | {1'b0, air_mode, 2'b00, air_fan};
            frame[5] = {(r.power ? POWER_ON_CODE : POWER_OFF_CODE), 3'b000,
                        (r.swing ? SWING_AUTO_CODE : SWING_FIXED_CODE)};
            frame[6] = 8'h00;
            frame[7] = 8'h00;
            sum = 8'h00;
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                sum = sum + {4'h0, frame[i][7:4]} + {4'h0, frame[i][3:0]};
            end
            frame[FRAME_LEN-1] = sum;
        endfunction

        // Called for every accepted request, in acceptance order.
        function void take_request(t_request r);
            t_pair       p;
            int unsigned bit_no;
            if (r.action == ACT_START) begin
                build_frame(r);
                pair_idx     = 0;
                frame_active = 1'b1;
                return;
            end
            if (!frame_active) return;
            p.last = 1'b0;
            if (pair_idx == 0) begin
                p.mark_us  = timing[CFG_HEADER_MARK];
                p.space_us = timing[CFG_HEADER_SPACE];
            end else if (pair_idx <= FRAME_BITS) begin
                bit_no     = pair_idx - 1;
                p.mark_us  = timing[CFG_BIT_MARK];
                p.space_us = frame[bit_no >> 3][bit_no & 7] ? timing[CFG_ONE_SPACE]
                                                            : timing[CFG_ZERO_SPACE];
            end else begin
                p.mark_us  = timing[CFG_BIT_MARK];
                p.space_us = timing[CFG_GAP_SPACE];
                p.last     = 1'b1;
            end
            if (p.last) begin
                frame_active = 1'b0;
                pair_idx     = 0;
            end else begin
                pair_idx = pair_idx + 1;
            end
            pending_pairs.push_back(p);
        endfunction

        function void match_pair(logic [15:0] mark_us, logic [15:0] space_us, logic last);
            t_pair want;
            if (pending_pairs.size() == 0) begin
                $error("unexpected pair: mark_us=%0d space_us=%0d last=%0b",
                       mark_us, space_us, last);
                error_count++;
                return;
            end
            want = pending_pairs.pop_front();
            if (mark_us !== want.mark_us) begin
                $error("mark_us: expected %0d, got %0d", want.mark_us, mark_us);
                error_count++;
            end
            if (space_us !== want.space_us) begin
                $error("space_us: expected %0d, got %0d", want.space_us, space_us);
                error_count++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, last);
                error_count++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_idx;
    logic [DUR_W-1:0]  i_cfg_data;

    acir_in_if  in_ch ();
    acir_out_if out_ch ();

    ir_pair_tracker tracker;
    int unsigned    rx_hold_cycles;
    int unsigned    burst_left;
    int unsigned    live_items;
    int unsigned    cycle_count;

    ac_ir_frame_encoder_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Every pair transfer is checked against the oldest owed pair. The output
    // is registered, so the request behind it was noted at an earlier edge.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            tracker.match_pair(out_ch.mark_us, out_ch.space_us, out_ch.last);
        end
    end

    // Receiver pacing: stretches of always-ready, coin-flip, mostly-stalled
    // and periodic ready. A long hold requested by the stimulus overrides
    // the pattern until its count runs out.
    initial begin : rx_pacing
        int unsigned rx_mode;
        int unsigned span;
        int unsigned tick;
        out_ch.ready = 1'b0;
        tick = 0;
        forever begin
            rx_mode = $urandom_range(0, 3);
            span    = $urandom_range(16, 160);
            repeat (span) begin
                @(negedge i_clk);
                tick++;
                if (rx_hold_cycles > 0) begin
                    out_ch.ready <= 1'b0;
                    rx_hold_cycles--;
                end else begin
                    case (rx_mode)
                        0: out_ch.ready <= 1'b1;
                        1: out_ch.ready <= 1'($urandom_range(0, 1));
                        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: out_ch.ready <= (tick % 3 != 0);
                    endcase
                end
            end
        end
    end

    // The run ends here as failed if it is still going at the cycle limit.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** ac_ir_frame_encoder_core: FAILED **");
        $finish;
    end

    function automatic t_request rand_start();
        t_request r;
        r.action = ACT_START;
        // Half the temperatures sit around the clamp limits.
        r.temp_c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(14, 32));
        r.mode   = 3'($urandom_range(0, 7));
        r.fan    = 2'($urandom_range(0, 3));
        r.swing  = 1'($urandom_range(0, 1));
        r.power  = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Next requests carry random settings too; the block ignores them.
    function automatic t_request next_req();
        t_request r;
        r        = rand_start();
        r.action = ACT_NEXT;
        return r;
    endfunction

    function automatic t_request fixed_start(logic [7:0] temp, logic [2:0] mode,
                                             logic [1:0] fan, logic swing, logic power);
        t_request r;
        r.action = ACT_START;
        r.temp_c = temp;
        r.mode   = mode;
        r.fan    = fan;
        r.swing  = swing;
        r.power  = power;
        return r;
    endfunction

    // Offers one request from the next falling edge and holds it until the
    // transfer; the tracker notes it at that edge.
    task automatic send_request(input t_request r);
        @(negedge i_clk);
        in_ch.valid  <= 1'b1;
        in_ch.action <= r.action;
        in_ch.temp_c <= r.temp_c;
        in_ch.mode   <= r.mode;
        in_ch.fan    <= r.fan;
        in_ch.swing  <= r.swing;
        in_ch.power  <= r.power;
        do begin
            @(posedge i_clk);
        end while (in_ch.ready !== 1'b1);
        tracker.take_request(r);
    endtask

    // Sender pacing: bursts of random length, each followed by a random gap.
    // Some gaps are zero, so long stretches go by with valid held high.
    task automatic push(input t_request r);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
        // Next requests while no frame is active are dropped by the block.
        if (r.action == ACT_START || tracker.frame_active) live_items++;
        send_request(r);
    endtask

    task automatic send_nexts(input int unsigned n);
        repeat (n) push(next_req());
    endtask

    // Ends any frame in flight, drops valid and waits for every owed pair,
    // then keeps waiting in case a dropped request is still in the block.
    task automatic settle();
        while (tracker.frame_active) push(next_req());
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (tracker.pending_pairs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all six timing registers in register order. Only called
    // after settle(), so no request or pair is in flight.
    task automatic write_timings(input t_timings values);
        t_cfg_reg reg_sel;
        reg_sel = reg_sel.first();
        repeat (reg_sel.num()) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_sel;
            i_cfg_data <= values[reg_sel];
            tracker.set_timing(reg_sel, values[reg_sel]);
            reg_sel = reg_sel.next();
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly complete frames with random settings; the rest are frames cut
    // short by a restart, stray next requests and back-to-back starts.
    task automatic run_random(input int unsigned n_items, input bit long_hold);
        int unsigned first;
        int unsigned pick;
        bit          hold_done;
        first     = live_items;
        hold_done = !long_hold;
        while (live_items - first < n_items) begin
            if (!hold_done && live_items - first >= n_items / 3) begin
                // The receiver stalls for a long time while requests keep
                // coming, so the output register fills and the input stalls.
                rx_hold_cycles = LONG_HOLD;
                hold_done      = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                push(rand_start());
                if ($urandom_range(0, 9) == 0) begin
                    send_nexts($urandom_range(1, FRAME_PAIRS - 1));
                end else begin
                    send_nexts(FRAME_PAIRS);
                end
            end else if (pick < 90) begin
                send_nexts($urandom_range(1, 6));
            end else begin
                push(rand_start());
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] edge_temps [8];
        t_timings   plan;
        tracker        = new();
        rx_hold_cycles = 0;
        burst_left     = 0;
        live_items     = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_HEADER_MARK;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.action   = ACT_NEXT;
        in_ch.temp_c   = '0;
        in_ch.mode     = '0;
        in_ch.fan      = '0;
        in_ch.swing    = 1'b0;
        in_ch.power    = 1'b0;
        edge_temps     = '{8'd0, 8'd255, 8'd15, 8'd16, 8'd30, 8'd31, 8'd23, 8'd128};

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset timings. Next requests before any frame
        // must give nothing.
        send_nexts(2);
        // Every mode code including fan-only and the unused ones, every fan
        // code, both swing and power values, temperatures at and past the
        // clamp limits.
        for (int i = 0; i < 8; i++) begin
            push(fixed_start(edge_temps[i], 3'(i), 2'(i), i[0], i[1]));
            if (i == 3) begin
                // Restart in the middle of a frame.
                send_nexts(20);
                push(fixed_start(8'd22, 3'd1, 2'd3, 1'b1, 1'b1));
            end
            send_nexts(FRAME_PAIRS);
        end
        // Next requests just after a footer go back to being dropped.
        send_nexts(2);
        settle();
        run_random(180, 1'b0);
        settle();

        // All timings at zero, with the long receiver hold.
        plan = '{default: 16'h0000};
        write_timings(plan);
        run_random(180, 1'b1);
        settle();

        // All timings at their maximum.
        plan = '{default: 16'hFFFF};
        write_timings(plan);
        run_random(180, 1'b0);
        settle();

        // Distinct random timings, so that a swapped register shows up.
        foreach (plan[i]) plan[i] = 16'($urandom_range(0, 65535));
        write_timings(plan);
        run_random(190, 1'b1);
        settle();

        repeat (10) @(posedge i_clk);
        if (tracker.error_count == 0 && tracker.pending_pairs.size() == 0) begin
            $display("** ac_ir_frame_encoder_core: PASSED **");
        end else begin
            $display("** ac_ir_frame_encoder_core: FAILED **");
        end
        $finish;
    end

endmodule
